[hw/rtl/alu1632_pkg.sv]
// Shared types and constants of the 16/32-bit ALU with status flags.
package alu1632_pkg;

    localparam int DATA_W = 32;
    localparam int HALF_W = 16;

    localparam logic [DATA_W-1:0] FULL_MASK     = 32'hffff_ffff;
    localparam logic [DATA_W-1:0] LOW_HALF_MASK = 32'h0000_ffff;

    // Bit positions within the status field
    localparam int ST_ZERO = 0;
    localparam int ST_FLAG = 1;
    localparam int ST_W    = 2;

    typedef enum logic [2:0] {
        OP_AND    = 3'd0,
        OP_OR     = 3'd1,
        OP_ADD    = 3'd2,
        OP_SUB    = 3'd3,
        OP_SATADD = 3'd4,
        OP_SATSUB = 3'd5,
        OP_MUL    = 3'd6,
        OP_NONE   = 3'd7
    } t_opcode;

endpackage

[hw/rtl/alu1632_in_if.sv]
// Operation channel: opcode, width select and two operands with valid/ready.
interface alu1632_in_if;
    import alu1632_pkg::*;

    logic              valid;
    logic              ready;
    t_opcode           opcode;
    logic              wide_mode;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;

    modport source (output valid, output opcode, output wide_mode,
                    output operand_a, output operand_b, input ready);
    modport sink   (input valid, input opcode, input wide_mode,
                    input operand_a, input operand_b, output ready);
endinterface

[hw/rtl/alu1632_out_if.sv]
// Result channel: result word and two-bit status with valid/ready.
interface alu1632_out_if;
    import alu1632_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] alu_result;
    logic [ST_W-1:0]   status;

    modport source (output valid, output alu_result, output status, input ready);
    modport sink   (input valid, input alu_result, input status, output ready);
endinterface

[hw/rtl/alu_16_32_with_flags.sv]
// Top level of the pipelined 16/32-bit integer ALU with status flags.
//
// Usage:
//   i_in  carries one operation per transfer: opcode, wide_mode (1 = 32-bit),
//         operand_a and operand_b. In 16-bit mode only the low halves count.
//   o_out carries alu_result and status (bit 0 zero, bit 1 overflow,
//         saturation or all-ones) for each operation, in order.
//   Throughput: one operation per cycle, sustained while the receiver does not stall.
//   Pipeline: three register stages (operand capture, arithmetic, flag
//         resolution).
//   The arithmetic stage holds one 33-bit add, one 33-bit subtract and one
//         16x16 multiplier; the flag stage holds the clamp and zero compare.
//   Reset (i_rst_n low, synchronous) clears all stage valid bits; no
//         payload is cleared.
//   When the receiver stalls the whole pipe holds; i_in.ready drops only
//         while a result is waiting at the output and o_out.ready is low.
module alu_16_32_with_flags (
    input  logic          i_clk,
    input  logic          i_rst_n,
    alu1632_in_if.sink    i_in,
    alu1632_out_if.source o_out
);
    import alu1632_pkg::*;

    logic w_adv;

    // Stage 1: masked operands
    logic              r_v1;
    t_opcode           r_op1;
    logic              r_wide1;
    logic [DATA_W-1:0] r_a1;
    logic [DATA_W-1:0] r_b1;
    logic [DATA_W-1:0] n_mask1;

    // Stage 2: raw arithmetic value and operand signs
    logic              r_v2;
    t_opcode           r_op2;
    logic              r_wide2;
    logic [DATA_W:0]   r_val2;
    logic              r_sa2;
    logic              r_sb2;
    logic [DATA_W:0]   n_val2;
    logic [DATA_W:0]   w_sum;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] w_prod;

    // Stage 3: output register
    logic              r_v3;
    logic [DATA_W-1:0] r_res3;
    logic [ST_W-1:0]   r_st3;
    logic [DATA_W-1:0] n_res3;
    logic              n_flag3;
    logic              n_zen3;
    logic [DATA_W-1:0] w_mask2;
    logic              w_sign2;
    logic              w_carry2;

    // Advance the whole pipe unless a result is held at the output
    assign w_adv      = !r_v3 || o_out.ready;
    assign i_in.ready = w_adv;

    assign n_mask1 = i_in.wide_mode ? FULL_MASK : LOW_HALF_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op1   <= i_in.opcode;
            r_wide1 <= i_in.wide_mode;
            r_a1    <= i_in.operand_a & n_mask1;
            r_b1    <= i_in.operand_b & n_mask1;

            r_op2   <= r_op1;
            r_wide2 <= r_wide1;
            r_val2  <= n_val2;
            r_sa2   <= r_wide1 ? r_a1[DATA_W-1] : r_a1[HALF_W-1];
            r_sb2   <= r_wide1 ? r_b1[DATA_W-1] : r_b1[HALF_W-1];

            r_res3  <= n_res3;
            r_st3   <= {n_flag3, n_zen3 && (n_res3 == '0)};
        end
    end

    assign w_sum  = {1'b0, r_a1} + {1'b0, r_b1};
    assign w_diff = {1'b0, r_a1} - {1'b0, r_b1};
    assign w_prod = r_a1[HALF_W-1:0] * r_b1[HALF_W-1:0];

    always_comb begin
        case (r_op1)
            OP_AND:    n_val2 = {1'b0, r_a1 & r_b1};
            OP_OR:     n_val2 = {1'b0, r_a1 | r_b1};
            OP_ADD:    n_val2 = w_sum;
            OP_SATADD: n_val2 = w_sum;
            OP_SUB:    n_val2 = w_diff;
            OP_SATSUB: n_val2 = w_diff;
            OP_MUL:    n_val2 = {1'b0, w_prod};
            default:   n_val2 = '0;
        endcase
    end

    assign w_mask2  = r_wide2 ? FULL_MASK : LOW_HALF_MASK;
    assign w_sign2  = r_wide2 ? r_val2[DATA_W-1] : r_val2[HALF_W-1];
    assign w_carry2 = r_wide2 ? r_val2[DATA_W] : r_val2[HALF_W];

    always_comb begin
        n_res3  = '0;
        n_flag3 = 1'b0;
        n_zen3  = 1'b1;
        case (r_op2)
            OP_AND, OP_OR: begin
                n_res3  = r_val2[DATA_W-1:0];
                n_flag3 = (r_val2[DATA_W-1:0] == w_mask2);
            end
            OP_ADD: begin
                n_res3  = r_val2[DATA_W-1:0] & w_mask2;
                n_flag3 = (r_sa2 == r_sb2) && (w_sign2 != r_sa2);
            end
            OP_SUB: begin
                n_res3  = r_val2[DATA_W-1:0] & w_mask2;
                n_flag3 = (r_sa2 != r_sb2) && (w_sign2 != r_sa2);
            end
            OP_SATADD: begin
                n_res3  = w_carry2 ? w_mask2 : (r_val2[DATA_W-1:0] & w_mask2);
                n_flag3 = w_carry2;
            end
            OP_SATSUB: begin
                // Borrow out of the zero-extended subtract means clamp to zero
                n_res3  = r_val2[DATA_W] ? '0 : r_val2[DATA_W-1:0];
                n_flag3 = r_val2[DATA_W];
                n_zen3  = !r_val2[DATA_W];
            end
            OP_MUL: begin
                n_res3 = r_wide2 ? '0 : r_val2[DATA_W-1:0];
                n_zen3 = !r_wide2;
            end
            default: begin
                n_zen3 = 1'b0;
            end
        endcase
    end

    assign o_out.valid      = r_v3;
    assign o_out.alu_result = r_res3;
    assign o_out.status     = r_st3;

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input refused while output stage empty");

    a_transfer_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v1)
        else $error("accepted operation not captured");

    a_zero_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status[ST_ZERO]) |-> (o_out.alu_result == '0))
        else $error("zero status with nonzero result");

    a_advance_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_adv) |=> o_out.valid)
        else $error("operation lost between arithmetic and output stage");
`endif

endmodule
